@@ rtl/core/sit_pkg.sv @@
// Shared types and constants for the sorted id index table.
package sit_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        REQ_SEARCH = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_HIT,
        S_INS,
        S_INS_NEW,
        S_DEL,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/sit_mem.sv @@
// Key and slot storage: one write port, one read port with registered data.
module sit_mem
    import sit_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [KEY_W-1:0] i_wkey,
    input  logic [AW-1:0]           i_wslot,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [KEY_W-1:0] o_rkey,
    output logic [AW-1:0]           o_rslot
);

    logic signed [KEY_W-1:0] r_key_mem  [DEPTH];
    logic [AW-1:0]           r_slot_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rkey;
    logic [AW-1:0]           r_rslot;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr]  <= i_wkey;
            r_slot_mem[i_waddr] <= i_wslot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rkey  <= r_key_mem[i_raddr];
        r_rslot <= r_slot_mem[i_raddr];
    end

    assign o_rkey  = r_rkey;
    assign o_rslot = r_rslot;

endmodule

@@ rtl/core/sorted_id_index_table_top.sv @@
// Sorted id index table: sequencer, search/shift datapath and storage.
//
//  channel   signals                                  handshake
//  request   i_req_type, i_key                        start & !busy
//  result    o_status, o_slot, o_entry_count          o_done, one cycle
//
// One shared memory, one read and one write a cycle; n keys stored, p = sorted position.
//   search: S_SEARCH and S_CMP per halving step, then S_HIT; insert: search, shift the
//   n - p entries up, write the key; delete: search + one compact/renumber sweep.
// The result strobe is registered, rising in the cycle after the final state.
// Reset clears the sequencer and count; storage holds garbage until written.
// busy stays high from accept until the result strobe; o_done cannot be stalled.
module sorted_id_index_table_top
    import sit_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_req_type,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [7:0]              o_slot,
    output logic [8:0]              o_entry_count
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW  = (AW > 8) ? AW : 8;
    localparam int CXW = (CW > 9) ? CW : 9;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx, r_pos, n_pos;
    logic [AW-1:0] r_gone, n_gone;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_waddr, n_waddr;
    logic          r_done;
    t_status       r_status;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_cnt_out;

    // memory port
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr, mem_raddr, mem_wslot, rd_slot;
    logic signed [KEY_W-1:0] mem_wkey, rd_key;

    // result strobe
    logic          emit;
    t_status       emit_status;
    logic [AW-1:0] emit_slot;

    logic [CW-1:0] mid_c;
    logic [CW:0]   idx_inc;
    logic          hit;
    logic [AW-1:0] fix_slot;

    sit_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wkey  (mem_wkey),
        .i_wslot (mem_wslot),
        .i_raddr (mem_raddr),
        .o_rkey  (rd_key),
        .o_rslot (rd_slot)
    );

    assign mid_c   = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_inc = {1'b0, r_idx} + 1'b1;
    assign hit     = (r_lo < r_count) && (rd_key == r_key);
    // delete renumbers slots above the removed one while compacting
    assign fix_slot = ((r_req == REQ_DELETE) && (rd_slot > r_gone)) ?
                      rd_slot - 1'b1 : rd_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_gone  <= n_gone;
        r_waddr <= n_waddr;
        if (emit) begin
            r_status  <= emit_status;
            r_slot    <= emit_slot;
            r_cnt_out <= n_count;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_gone      = r_gone;
        n_pend      = 1'b0;
        n_waddr     = r_waddr;
        mem_raddr   = r_lo[AW-1:0];
        mem_we      = r_pend;
        mem_waddr   = r_waddr;
        mem_wkey    = rd_key;
        mem_wslot   = fix_slot;
        emit        = 1'b0;
        emit_status = ST_NOT_FOUND;
        emit_slot   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = t_req'(i_req_type);
                    n_key   = i_key;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid_c;
                    mem_raddr = mid_c[AW-1:0];
                    n_state   = S_CMP;
                end else begin
                    // probe the lower bound; data lands in S_HIT
                    mem_raddr = r_lo[AW-1:0];
                    n_state   = S_HIT;
                end
            end
            S_CMP: begin
                if (rd_key < r_key) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SEARCH;
            end
            S_HIT: begin
                n_pos  = r_lo;
                n_gone = rd_slot;
                unique case (r_req)
                    REQ_SEARCH: begin
                        emit        = 1'b1;
                        emit_status = hit ? ST_OK : ST_NOT_FOUND;
                        emit_slot   = hit ? rd_slot : '0;
                        n_state     = S_IDLE;
                    end
                    REQ_INSERT: begin
                        if (hit) begin
                            emit        = 1'b1;
                            emit_status = ST_DUPLICATE;
                            n_state     = S_IDLE;
                        end else if (r_count >= CW'(TABLE_DEPTH)) begin
                            emit        = 1'b1;
                            emit_status = ST_FULL;
                            n_state     = S_IDLE;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_INS;
                        end
                    end
                    REQ_DELETE: begin
                        if (hit) begin
                            n_idx   = '0;
                            n_state = S_DEL;
                        end else begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS: begin
                // move entry idx-1 up to idx, one per cycle, highest first
                if (r_idx > r_pos) begin
                    mem_raddr = AW'(r_idx - 1'b1);
                    n_pend    = 1'b1;
                    n_waddr   = r_idx[AW-1:0];
                    n_idx     = r_idx - 1'b1;
                end else begin
                    n_state = S_INS_NEW;
                end
            end
            S_INS_NEW: begin
                mem_we      = 1'b1;
                mem_waddr   = r_pos[AW-1:0];
                mem_wkey    = r_key;
                mem_wslot   = r_count[AW-1:0];
                n_count     = r_count + 1'b1;
                emit        = 1'b1;
                emit_status = ST_OK;
                emit_slot   = r_count[AW-1:0];
                n_state     = S_IDLE;
            end
            S_DEL: begin
                // rewrite every surviving entry: skip the removed one, fix slots
                if (idx_inc < {1'b0, r_count}) begin
                    mem_raddr = (r_idx < r_pos) ? r_idx[AW-1:0] : idx_inc[AW-1:0];
                    n_pend    = 1'b1;
                    n_waddr   = r_idx[AW-1:0];
                    n_idx     = idx_inc[CW-1:0];
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_count     = r_count - 1'b1;
                emit        = 1'b1;
                emit_status = ST_OK;
                emit_slot   = r_gone;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    logic [SW-1:0]  slot_ext;
    logic [CXW-1:0] cnt_ext;

    assign slot_ext      = SW'(r_slot);
    assign cnt_ext       = CXW'(r_cnt_out);
    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot        = slot_ext[7:0];
    assign o_entry_count = cnt_ext[8:0];

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == S_INS_NEW) && r_pend))
        else $error("shift write collides with new entry write");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not raise busy");
`endif

endmodule
